// File: sv/rvh_pkg.sv
`timescale 1ns / 1ps

package rvh_pkg;

	localparam int MAX_BINS   = 256;
	localparam int COUNT_BITS = 32;

	localparam int SAMPLE_W   = 16;
	localparam int MODE_W     = 2;
	localparam int IDX_W      = 8;
	localparam int BINS_CFG_W = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_W      = 32;
	localparam int HIT_W      = 8;

	localparam int BIN_BITS   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	// quotient never exceeds the bin count, which fits the register width
	localparam int QUO_BITS   = BINS_CFG_W;
	localparam int DIVIDEND_W = SAMPLE_W + QUO_BITS;
	localparam int DIV_CNT_W  = $clog2(QUO_BITS);

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_COUNT       = 2'd0,
		MODE_READ        = 2'd1,
		MODE_CLEAR_TOTAL = 2'd2,
		MODE_UNUSED      = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_VALUE   = 2'd0,
		REG_MAX_VALUE   = 2'd1,
		REG_BINS_IN_USE = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_FINISH
	} state_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic [OUT_W-1:0] out32(input count_t v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_W-1:0];
	endfunction

endpackage

// File: sv/rvh_cfg_if.sv
`timescale 1ns / 1ps

interface rvh_cfg_if import rvh_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/rvh_item_if.sv
`timescale 1ns / 1ps

interface rvh_item_if import rvh_pkg::*;;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [SAMPLE_W-1:0] sample;
	logic [IDX_W-1:0]    bin_index;

	modport source (output valid, mode, sample, bin_index, input ready);
	modport sink (input valid, mode, sample, bin_index, output ready);
endinterface

// File: sv/rvh_result_if.sv
`timescale 1ns / 1ps

interface rvh_result_if import rvh_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] bin_count;
	logic [OUT_W-1:0] total_count;
	logic             in_range;
	logic [HIT_W-1:0] bin_hit;

	modport source (output valid, bin_count, total_count, in_range, bin_hit, input ready);
	modport sink (input valid, bin_count, total_count, in_range, bin_hit, output ready);
endinterface

// File: sv/ranged_value_histogram.sv
`timescale 1ns / 1ps

// Ranged histogram of 16-bit samples into equal-width bins.
// cfg: register writes (min_value, max_value, bins_in_use), always ready; write
//   only while the block is idle.
// item: one transfer per operation: mode 0 counts a sample, mode 1 reads and
//   clears a bin, mode 2 clears the total. Every item gives one transfer on result.
// Steps per item after accept, before the result is valid:
//   mode 0 in range, span nonzero: 9 restoring divider steps, one bit
//     per cycle, then a read and a write of the bin memory
//   mode 0 with empty span, mode 1: memory read, then update
//   other items: the update only
// One item is in flight at a time; item.ready is high only while idle.
// The output register lets the next item be taken while a result waits; the
// final update holds while that register is full and result.ready is low.
// Reset clears all counts at once through per-bin valid bits; no clearing
// pass is needed and items are taken from the first cycle after reset.
module ranged_value_histogram import rvh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rvh_cfg_if.sink      cfg,
	rvh_item_if.sink     item,
	rvh_result_if.source result
);

	logic [SAMPLE_W-1:0]   min_value_q;
	logic [SAMPLE_W-1:0]   max_value_q;
	logic [BINS_CFG_W-1:0] bins_in_use_q;
	logic [BINS_CFG_W-1:0] eff_bins;

	state_t state_q, state_d;
	logic   item_ready_c, div_en, rd_en, fin_en, out_free;
	logic   item_acc;

	mode_t                 mode_q;
	logic [IDX_W-1:0]      bin_index_q;
	logic [SAMPLE_W-1:0]   span_q;
	logic [DIVIDEND_W-1:0] work_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  mem_op_q;

	logic                  sample_inr;
	logic                  idx_ok;
	logic [SAMPLE_W-1:0]   sample_off;

	logic [SAMPLE_W:0]     rem_t;
	logic [SAMPLE_W:0]     rem_sub;
	logic                  rem_ge;
	logic [SAMPLE_W-1:0]   rem_next;
	logic [QUO_BITS-1:0]   quo;
	logic [BIN_BITS-1:0]   bin_clamped;
	logic [BIN_BITS-1:0]   rd_addr;

	count_t                mem [MAX_BINS];
	logic [MAX_BINS-1:0]   vld_q;
	count_t                rd_data_q;
	logic                  rd_vld_q;
	logic [BIN_BITS-1:0]   bin_q;
	count_t                old_count;
	logic                  wr_en;

	count_t                total_q, total_d;

	logic                  res_valid_q;
	logic [OUT_W-1:0]      res_bin_count_q;
	logic [OUT_W-1:0]      res_total_count_q;
	logic                  res_in_range_q;
	logic [HIT_W-1:0]      res_bin_hit_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_value_q   <= '0;
			max_value_q   <= '1;
			bins_in_use_q <= BINS_CFG_W'(256);
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_MIN_VALUE:   min_value_q   <= cfg.data[SAMPLE_W-1:0];
				REG_MAX_VALUE:   max_value_q   <= cfg.data[SAMPLE_W-1:0];
				REG_BINS_IN_USE: bins_in_use_q <= cfg.data[BINS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bins_in_use_q == '0)
			eff_bins = BINS_CFG_W'(1);
		else if (32'(bins_in_use_q) > MAX_BINS)
			eff_bins = BINS_CFG_W'(MAX_BINS);
		else
			eff_bins = bins_in_use_q;
	end

	// item decode at accept
	assign item_acc   = item.valid && item_ready_c;
	assign sample_inr = (item.sample >= min_value_q) && (item.sample <= max_value_q);
	assign idx_ok     = 32'(item.bin_index) < MAX_BINS;
	assign sample_off = item.sample - min_value_q;

	// control
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					case (mode_t'(item.mode))
						MODE_COUNT: begin
							if (!sample_inr)
								state_d = ST_FINISH;
							else if (max_value_q == min_value_q)
								state_d = ST_READ;
							else
								state_d = ST_DIV;
						end
						MODE_READ: state_d = idx_ok ? ST_READ : ST_FINISH;
						default:   state_d = ST_FINISH;
					endcase
				end
			end
			ST_DIV: begin
				if (cnt_q == DIV_CNT_W'(QUO_BITS - 1))
					state_d = ST_READ;
			end
			ST_READ:   state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready_c = 1'b0;
		div_en       = 1'b0;
		rd_en        = 1'b0;
		fin_en       = 1'b0;
		case (state_q)
			ST_IDLE:   item_ready_c = 1'b1;
			ST_DIV:    div_en = 1'b1;
			ST_READ:   rd_en = 1'b1;
			ST_FINISH: fin_en = out_free;
			default: ;
		endcase
	end

	assign item.ready = item_ready_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			mem_op_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_acc) begin
				cnt_q    <= '0;
				mem_op_q <= (mode_t'(item.mode) == MODE_COUNT && sample_inr)
					|| (mode_t'(item.mode) == MODE_READ && idx_ok);
			end else if (div_en) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	// restoring divider: work_q holds {remainder, dividend bits / quotient bits}
	assign rem_t    = {work_q[DIVIDEND_W-1:QUO_BITS], work_q[QUO_BITS-1]};
	assign rem_sub  = rem_t - {1'b0, span_q};
	assign rem_ge   = rem_t >= {1'b0, span_q};
	assign rem_next = rem_ge ? rem_sub[SAMPLE_W-1:0] : rem_t[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (item_acc) begin
			mode_q      <= mode_t'(item.mode);
			bin_index_q <= item.bin_index;
			span_q      <= max_value_q - min_value_q;
			// empty span: quotient zero selects bin 0
			if (max_value_q == min_value_q)
				work_q <= '0;
			else
				work_q <= DIVIDEND_W'(sample_off) * DIVIDEND_W'(eff_bins);
		end else if (div_en) begin
			work_q <= {rem_next, work_q[QUO_BITS-2:0], rem_ge};
		end
	end

	// sample equal to max yields the bin count itself; fold into the last bin
	assign quo = work_q[QUO_BITS-1:0];
	assign bin_clamped = (quo >= eff_bins) ? BIN_BITS'(eff_bins - BINS_CFG_W'(1))
		: BIN_BITS'(quo);
	assign rd_addr = (mode_q == MODE_READ) ? BIN_BITS'(bin_index_q) : bin_clamped;

	// bin memory
	assign old_count = rd_vld_q ? rd_data_q : '0;
	assign wr_en     = fin_en && mem_op_q && (mode_q == MODE_COUNT);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			bin_q     <= rd_addr;
		end
		if (wr_en)
			mem[bin_q] <= sat_inc(old_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
			if (fin_en && mem_op_q) begin
				// a read clears the bin by dropping its valid bit
				if (mode_q == MODE_COUNT)
					vld_q[bin_q] <= 1'b1;
				else
					vld_q[bin_q] <= 1'b0;
			end
		end
	end

	// total
	always_comb begin
		total_d = total_q;
		case (mode_q)
			MODE_COUNT:       total_d = mem_op_q ? sat_inc(total_q) : total_q;
			MODE_CLEAR_TOTAL: total_d = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			total_q <= '0;
		else if (fin_en)
			total_q <= total_d;
	end

	// output register
	assign out_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (fin_en)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_en) begin
			res_bin_count_q   <= (mode_q == MODE_READ && mem_op_q) ? out32(old_count) : '0;
			res_total_count_q <= out32(total_d);
			res_in_range_q    <= (mode_q == MODE_COUNT) && mem_op_q;
			res_bin_hit_q     <= (mode_q == MODE_COUNT && mem_op_q) ? HIT_W'(bin_q) : '0;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.bin_count   = res_bin_count_q;
	assign result.total_count = res_total_count_q;
	assign result.in_range    = res_in_range_q;
	assign result.bin_hit     = res_bin_hit_q;

endmodule

// File: sv/rvh_checker.sv
`timescale 1ns / 1ps

module rvh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_bin_count,
	input logic [31:0] res_total_count,
	input logic        res_in_range,
	input logic [7:0]  res_bin_hit
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_bin_count)
			&& $stable(res_total_count) && $stable(res_bin_hit))
		else $error("result changed while stalled");

	// one item in flight: no transfer in the cycle right after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while another is in flight");

	a_hit_needs_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_in_range |-> res_bin_hit == 8'd0)
		else $error("bin hit without in-range sample");

	// a counted sample leaves a nonzero total and reports no bin read
	a_count_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_in_range |-> res_total_count != 32'd0 && res_bin_count == 32'd0)
		else $error("inconsistent count result");

endmodule

bind ranged_value_histogram rvh_checker u_rvh_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.res_bin_count   (result.bin_count),
	.res_total_count (result.total_count),
	.res_in_range    (result.in_range),
	.res_bin_hit     (result.bin_hit)
);

// File: dv/ranged_value_histogram_tb.sv
`timescale 1ns / 1ps

module ranged_value_histogram_tb;
	import rvh_pkg::*;

	localparam int                   SETTLE_CYCLES = 16;
	localparam int                   STALL_LIMIT   = 3000;
	localparam int                   MAX_PRINTED   = 200;
	localparam logic [CFG_IDX_W-1:0] REG_UNLISTED  = 2'd3;

	typedef struct packed {
		logic [OUT_W-1:0] bin_count;
		logic [OUT_W-1:0] total_count;
		logic             in_range;
		logic [HIT_W-1:0] bin_hit;
	} readout_t;

	logic clk;
	logic arst_n;

	rvh_cfg_if    cfg_ch ();
	rvh_item_if   item_ch ();
	rvh_result_if result_ch ();

	ranged_value_histogram i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	// shadow of the block's registers and counts
	logic [SAMPLE_W-1:0]   lo_q;
	logic [SAMPLE_W-1:0]   hi_q;
	logic [BINS_CFG_W-1:0] bins_q;
	count_t                bin_tally [MAX_BINS];
	count_t                in_range_total;

	readout_t awaited_readouts [$];

	int mismatches;
	int items_sent;
	int readouts_checked;
	int reg_writes;
	int settings_used;
	int mode_seen [4];
	int item_idle_pct;
	int result_idle_pct;
	int stall_left;
	int quiet_cycles;

	always #5 clk = ~clk;

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		item_ch.valid    = 1'b0;
		item_ch.mode     = '0;
		item_ch.sample   = '0;
		item_ch.bin_index = '0;
		result_ch.ready  = 1'b0;
		lo_q             = '0;
		hi_q             = '1;
		bins_q           = BINS_CFG_W'(MAX_BINS);
		in_range_total   = '0;
		for (int i = 0; i < MAX_BINS; i++)
			bin_tally[i] = '0;
		mismatches       = 0;
		items_sent       = 0;
		readouts_checked = 0;
		reg_writes       = 0;
		settings_used    = 1;
		mode_seen        = '{0, 0, 0, 0};
		item_idle_pct    = 30;
		result_idle_pct  = 30;
		stall_left       = 0;
		quiet_cycles     = 0;
	end

	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	// one item applied to the shadow state; returns the readout it must produce
	function automatic readout_t histogram_update(mode_t m, logic [SAMPLE_W-1:0] s,
			logic [IDX_W-1:0] idx);
		readout_t    r;
		int unsigned nb;
		int unsigned span;
		int unsigned bin;
		r = '0;
		case (m)
			MODE_COUNT: begin
				if (s >= lo_q && s <= hi_q) begin
					nb = (bins_q == 0) ? 1 : ((bins_q > MAX_BINS) ? MAX_BINS : bins_q);
					span = int'(hi_q) - int'(lo_q);
					bin = (span == 0) ? 0 : ((int'(s) - int'(lo_q)) * nb) / span;
					// sample at max lands one past the end
					if (bin >= nb)
						bin = nb - 1;
					if (bin_tally[bin] != '1)
						bin_tally[bin] = bin_tally[bin] + 1'b1;
					if (in_range_total != '1)
						in_range_total = in_range_total + 1'b1;
					r.in_range = 1'b1;
					r.bin_hit  = bin[HIT_W-1:0];
				end
			end
			MODE_READ: begin
				if (idx < MAX_BINS) begin
					r.bin_count    = bin_tally[idx];
					bin_tally[idx] = '0;
				end
			end
			MODE_CLEAR_TOTAL: in_range_total = '0;
			default: ;
		endcase
		r.total_count = in_range_total;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// valid is left high after the transfer so back-to-back items need no toggle
	task automatic send_item(mode_t m, logic [SAMPLE_W-1:0] s, logic [IDX_W-1:0] idx);
		int gap;
		gap = pick_gap(item_idle_pct);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.mode      <= m;
		item_ch.sample    <= s;
		item_ch.bin_index <= idx;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		awaited_readouts.push_back(histogram_update(m, s, idx));
		items_sent++;
		mode_seen[m]++;
	endtask

	task automatic stop_items();
		item_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (awaited_readouts.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		stop_items();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// like send_item, valid stays high; the caller lowers it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			REG_MIN_VALUE:   lo_q = value;
			REG_MAX_VALUE:   hi_q = value;
			REG_BINS_IN_USE: bins_q = value[BINS_CFG_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic configure(logic [SAMPLE_W-1:0] lo, logic [SAMPLE_W-1:0] hi,
			logic [CFG_DATA_W-1:0] bins_word);
		wait_idle();
		write_reg(REG_MIN_VALUE, lo);
		write_reg(REG_MAX_VALUE, hi);
		write_reg(REG_BINS_IN_USE, bins_word);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (lo_q <= hi_q && r < 60)
			return SAMPLE_W'($urandom_range(lo_q, hi_q));
		if (r < 75) begin
			case ($urandom_range(0, 3))
				0: return lo_q;
				1: return hi_q;
				2: return lo_q - 1'b1;
				default: return hi_q + 1'b1;
			endcase
		end
		return SAMPLE_W'($urandom());
	endfunction

	task automatic send_random_item();
		int unsigned r;
		mode_t       m;
		r = $urandom_range(0, 99);
		if (r < 72)
			m = MODE_COUNT;
		else if (r < 89)
			m = MODE_READ;
		else if (r < 94)
			m = MODE_CLEAR_TOTAL;
		else
			m = MODE_UNUSED;
		send_item(m, pick_sample(), IDX_W'($urandom()));
	endtask

	// reset settings: full range, 256 bins
	task automatic test_reset_defaults();
		send_item(MODE_COUNT, 16'd0, 8'd0);
		send_item(MODE_COUNT, 16'hFFFF, 8'd0);
		send_item(MODE_COUNT, 16'd32768, 8'd0);
		send_item(MODE_COUNT, 16'hFFFE, 8'hFF);
		send_item(MODE_READ, 16'd0, 8'd255);
		send_item(MODE_READ, 16'hFFFF, 8'd0);
		send_item(MODE_UNUSED, 16'hFFFF, 8'hFF);
		send_item(MODE_CLEAR_TOTAL, 16'hFFFF, 8'hFF);
		send_item(MODE_READ, 16'd0, 8'd128);
	endtask

	task automatic test_range_edges();
		configure(16'd1000, 16'd2000, 16'd10);
		send_item(MODE_COUNT, 16'd999, 8'd0);
		send_item(MODE_COUNT, 16'd1000, 8'd0);
		send_item(MODE_COUNT, 16'd2000, 8'd0);
		send_item(MODE_COUNT, 16'd2001, 8'd0);
		send_item(MODE_READ, 16'd0, 8'd9);
		// bin outside the ten in use
		send_item(MODE_READ, 16'd0, 8'd200);
	endtask

	task automatic test_empty_span();
		configure(16'd500, 16'd500, 16'd7);
		send_item(MODE_COUNT, 16'd500, 8'd0);
		send_item(MODE_COUNT, 16'd499, 8'd0);
		send_item(MODE_COUNT, 16'd501, 8'd0);
		send_item(MODE_READ, 16'd0, 8'd0);
	endtask

	task automatic test_inverted_range();
		configure(16'd40000, 16'd100, 16'd256);
		send_item(MODE_COUNT, 16'd100, 8'd0);
		send_item(MODE_COUNT, 16'd40000, 8'd0);
		send_item(MODE_COUNT, 16'd20000, 8'd0);
	endtask

	// zero bins acts as one, oversize acts as MAX_BINS, unlisted index ignored
	task automatic test_bin_count_limits();
		configure(16'd0, 16'hFFFF, 16'd0);
		send_item(MODE_COUNT, 16'hFFFF, 8'd0);
		wait_idle();
		write_reg(REG_UNLISTED, 16'($urandom()));
		write_reg(REG_BINS_IN_USE, 16'hFFFF);
		cfg_ch.valid <= 1'b0;
		settings_used++;
		send_item(MODE_COUNT, 16'hFFFF, 8'd0);
	endtask

	task automatic test_random();
		int unsigned           lo;
		int unsigned           hi;
		int unsigned           tmp;
		logic [CFG_DATA_W-1:0] bins_word;
		int                    pct [10];
		pct = '{20, 0, 40, 10, 60, 25, 0, 15, 0, 5};
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin
					lo = 0; hi = 65535; bins_word = 16'd256;
				end
				1: begin
					lo = 0; hi = 65535; bins_word = 16'd1;
				end
				2: begin
					lo = 65535; hi = 65535; bins_word = 16'($urandom_range(1, 256));
				end
				3: begin
					lo = 0; hi = 0; bins_word = 16'd256;
				end
				default: begin
					lo = $urandom_range(0, 65535);
					hi = $urandom_range(lo, 65535);
					if ($urandom_range(0, 7) == 0) begin
						tmp = lo; lo = hi; hi = tmp;
					end
					bins_word = ($urandom_range(0, 3) == 0) ? 16'($urandom())
							: 16'($urandom_range(1, 256));
				end
			endcase
			configure(16'(lo), 16'(hi), bins_word);
			item_idle_pct   = pct[p];
			result_idle_pct = pct[9-p];
			for (int n = 0; n < 125; n++) begin
				// hold the sender until the block has fully drained
				if (p == 5 && n == 60) begin
					stop_items();
					wait_drained();
				end
				send_random_item();
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_range_edges();
		test_empty_span();
		test_inverted_range();
		test_bin_count_limits();
		test_random();
		wait_idle();
		$display("Sent %0d items (count %0d, read %0d, clear %0d, unused %0d)",
				items_sent, mode_seen[MODE_COUNT], mode_seen[MODE_READ],
				mode_seen[MODE_CLEAR_TOTAL], mode_seen[MODE_UNUSED]);
		$display("Checked %0d readouts over %0d settings, %0d register writes, %0d mismatches",
				readouts_checked, settings_used, reg_writes, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// readout checker and receiver stalls
	always @(posedge clk) begin : result_side
		readout_t want;
		int       gap;
		if (result_ch.valid && result_ch.ready) begin
			if (awaited_readouts.size() == 0) begin
				report_mismatch("readout with nothing pending", result_ch.total_count, '0);
			end else begin
				want = awaited_readouts.pop_front();
				readouts_checked++;
				if (result_ch.bin_count !== want.bin_count)
					report_mismatch("bin_count", result_ch.bin_count, want.bin_count);
				if (result_ch.total_count !== want.total_count)
					report_mismatch("total_count", result_ch.total_count, want.total_count);
				if (result_ch.in_range !== want.in_range)
					report_mismatch("in_range", OUT_W'(result_ch.in_range),
							OUT_W'(want.in_range));
				if (result_ch.bin_hit !== want.bin_hit)
					report_mismatch("bin_hit", OUT_W'(result_ch.bin_hit), OUT_W'(want.bin_hit));
			end
		end
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			gap = pick_gap(result_idle_pct);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				stall_left = gap - 1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// end the run if no transfer of any kind happens for too long
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d cycles without a transfer", quiet_cycles);
			$display("Verification failed");
			$finish;
		end
	end

endmodule

// File: filelist.f
sv/rvh_pkg.sv
sv/rvh_cfg_if.sv
sv/rvh_item_if.sv
sv/rvh_result_if.sv
sv/ranged_value_histogram.sv
sv/rvh_checker.sv
dv/ranged_value_histogram_tb.sv
